FILE: rtl/core/sps_pkg.sv
// Shared types, constants and coil pattern tables of the stepper phase sequencer.
package sps_pkg;

   localparam int ELAPSED_WIDTH_DEF = 26;
   localparam int DELAY_W           = 25;
   localparam int POS_W             = 16;
   localparam int SPR_W             = 16;
   localparam int RPM_W             = 10;
   localparam int DIV_W             = 26;
   localparam int CSR_IDX_W         = 2;
   localparam int CSR_DATA_W        = 16;

   localparam logic [DIV_W-1:0]   MINUTE_US   = 26'd60000000;
   localparam logic [SPR_W-1:0]   SPR_RESET   = 16'd200;
   localparam logic [SPR_W-1:0]   SPR_MIN     = 16'd2;
   localparam logic [RPM_W-1:0]   RPM_RESET   = 10'd60;
   localparam logic [RPM_W-1:0]   RPM_MIN     = 10'd1;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 25'd5000;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_MOVE    = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEPS_PER_REV = 2'd0,
      CSR_SPEED_RPM     = 2'd1,
      CSR_FOUR_WIRE     = 2'd2,
      CSR_COIL_EN_USED  = 2'd3
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic item_en;
      logic load_prod;
      logic div_start;
      logic div_pos_sel;
      logic store_delay;
      logic store_pos_mod;
   } sps_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic recalc_req;
      logic div_done;
   } sps_status_type;

   function automatic logic [1:0] full2_pat(input logic [1:0] idx);
      logic [1:0] pat;
      case (idx)
         2'd0: pat = 2'h2;
         2'd1: pat = 2'h3;
         2'd2: pat = 2'h1;
         default: pat = 2'h0;
      endcase
      return pat;
   endfunction

   function automatic logic [3:0] full4_pat(input logic [1:0] idx);
      logic [3:0] pat;
      case (idx)
         2'd0: pat = 4'h5;
         2'd1: pat = 4'h6;
         2'd2: pat = 4'hA;
         default: pat = 4'h9;
      endcase
      return pat;
   endfunction

   function automatic logic [3:0] half4_pat(input logic [2:0] idx);
      logic [3:0] pat;
      case (idx)
         3'd0: pat = 4'h1;
         3'd1: pat = 4'h5;
         3'd2: pat = 4'h4;
         3'd3: pat = 4'h6;
         3'd4: pat = 4'h2;
         3'd5: pat = 4'hA;
         3'd6: pat = 4'h8;
         default: pat = 4'h9;
      endcase
      return pat;
   endfunction

   // Two-wire half step: the pins written are also the coils enabled.
   function automatic logic [1:0] half2_mask(input logic [2:0] idx);
      logic [1:0] m;
      case (idx)
         3'd0, 3'd4: m = 2'd1;
         3'd2, 3'd6: m = 2'd2;
         default: m = 2'd3;
      endcase
      return m;
   endfunction

   function automatic logic [1:0] half2_val(input logic [2:0] idx);
      logic [1:0] v;
      case (idx)
         3'd1, 3'd2: v = 2'd2;
         3'd3: v = 2'd3;
         3'd4, 3'd5: v = 2'd1;
         default: v = 2'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/sps_channels_if.sv
// Valid/ready channel interfaces for the sequencer's command and result items.
interface sps_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic signed [15:0] move_steps;
   logic              half_mode;

   modport source (output valid, output op, output move_steps, output half_mode,
                   input ready);
   modport sink (input valid, input op, input move_steps, input half_mode,
                 output ready);
endinterface

interface sps_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  coil_pins;
   logic [1:0]  coil_enables;
   logic        busy_res;
   logic        stepped;
   logic [15:0] position;

   modport source (output valid, output coil_pins, output coil_enables,
                   output busy_res, output stepped, output position, input ready);
   modport sink (input valid, input coil_pins, input coil_enables,
                 input busy_res, input stepped, input position, output ready);
endinterface

FILE: rtl/core/sps_ctrl.sv
// Controller: item handshake and the sequence that recomputes the step delay.
module sps_ctrl
   import sps_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  sps_status_type status,
   output sps_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE        = 6'b000001,
      ST_PREP        = 6'b000010,
      ST_START_DELAY = 6'b000100,
      ST_WAIT_DELAY  = 6'b001000,
      ST_START_POS   = 6'b010000,
      ST_WAIT_POS    = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.item_en = req_valid && req_ready;
      case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_PREP: begin
            cmd.load_prod = 1'b1;
            state_in = ST_START_DELAY;
         end
         ST_START_DELAY: begin
            cmd.div_start = 1'b1;
            state_in = ST_WAIT_DELAY;
         end
         ST_WAIT_DELAY: begin
            if (status.div_done) begin
               cmd.store_delay = 1'b1;
               state_in = ST_START_POS;
            end
         end
         ST_START_POS: begin
            cmd.div_start = 1'b1;
            cmd.div_pos_sel = 1'b1;
            state_in = ST_WAIT_POS;
         end
         ST_WAIT_POS: begin
            if (status.div_done) begin
               cmd.store_pos_mod = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (status.recalc_req) begin
         state_in = ST_PREP;
      end
   end

   always_comb begin
      if (cmd.item_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/sps_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module sps_divider #(
   parameter int W = 26
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);

   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [W:0]       rem_try;
   logic             fits;

   assign rem_try = {rem_ff, quo_ff[W-1]};
   assign fits = rem_try >= {1'b0, dsr_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CNT_W'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = W'(rem_try - {1'b0, dsr_ff});
         end else begin
            rem_in = rem_try[W-1:0];
         end
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/core/sps_datapath.sv
// Datapath: configuration, motion state, step timing and coil pattern logic.
module sps_datapath
   import sps_pkg::*;
#(
   parameter int ELAPSED_WIDTH = ELAPSED_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  sps_cmd_type           cmd,
   output sps_status_type        status,
   input  logic [1:0]            op,
   input  logic signed [15:0]    move_steps,
   input  logic                  half_mode,
   output logic [3:0]            coil_pins,
   output logic [1:0]            coil_enables,
   output logic                  busy_res,
   output logic                  stepped,
   output logic [POS_W-1:0]      position
);

   localparam int CMP_W = (ELAPSED_WIDTH > DELAY_W) ? ELAPSED_WIDTH : DELAY_W;
   localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;

   // Configuration registers.
   logic [SPR_W-1:0] spr_ff;
   logic [RPM_W-1:0] rpm_ff;
   logic             four_wire_ff;
   logic             en_used_ff;

   // Motion state.
   logic [POS_W-1:0]         position_ff, position_in;
   logic [POS_W-1:0]         pos_mod_ff, pos_mod_in;
   logic                     forward_ff, forward_in;
   logic [15:0]              steps_ff, steps_in;
   logic [ELAPSED_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [DELAY_W-1:0]       delay_ff, delay_in;
   logic [DELAY_W-1:0]       full_delay_ff, full_delay_in;
   logic                     half_ff, half_in;
   logic [3:0]               pins_ff, pins_in;
   logic [1:0]               enables_ff, enables_in;
   logic                     stepped_ff, stepped_in;
   logic [DIV_W-1:0]         prod_ff;

   logic [SPR_W-1:0]         spr_eff;
   logic [RPM_W-1:0]         rpm_eff;
   logic [DIV_W-1:0]         div_dividend, div_divisor, div_quo, div_rem;
   logic                     div_done;
   logic [ELAPSED_WIDTH-1:0] elapsed_inc;
   logic                     slot;
   logic                     blocked;
   logic [1:0]               inc;
   logic [POS_W:0]           pos_base;
   logic [POS_W-1:0]         pos_next;
   logic [15:0]              raw;

   assign spr_eff = (spr_ff < SPR_MIN) ? SPR_MIN : spr_ff;
   assign rpm_eff = (rpm_ff < RPM_MIN) ? RPM_MIN : rpm_ff;

   assign status.recalc_req = csr_we && ((csr_index == CSR_STEPS_PER_REV) ||
                                         (csr_index == CSR_SPEED_RPM));
   assign status.div_done = div_done;

   // Delay is 60e6 / (rpm * spr); the remainder pass brings the position below spr.
   assign div_dividend = cmd.div_pos_sel ? DIV_W'(position_ff) : MINUTE_US;
   assign div_divisor  = cmd.div_pos_sel ? DIV_W'(spr_eff) : prod_ff;

   sps_divider #(.W(DIV_W)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign slot = (steps_ff != '0) && (CMP_W'(elapsed_inc) >= CMP_W'(delay_ff));
   assign blocked = half_ff && !four_wire_ff && !en_used_ff;
   assign inc = half_ff ? 2'd1 : 2'd2;
   assign pos_base = forward_ff ? ({1'b0, pos_mod_ff} + (POS_W+1)'(inc))
                                : ({1'b0, pos_mod_ff} + {1'b0, spr_eff} - (POS_W+1)'(inc));
   assign pos_next = (pos_base >= {1'b0, spr_eff}) ? POS_W'(pos_base - {1'b0, spr_eff})
                                                  : pos_base[POS_W-1:0];
   assign raw = move_steps;

   always_comb begin
      position_in = position_ff;
      pos_mod_in = pos_mod_ff;
      forward_in = forward_ff;
      steps_in = steps_ff;
      elapsed_in = elapsed_ff;
      delay_in = delay_ff;
      full_delay_in = full_delay_ff;
      half_in = half_ff;
      pins_in = pins_ff;
      enables_in = enables_ff;
      stepped_in = stepped_ff;

      if (cmd.store_delay) begin
         full_delay_in = div_quo[DELAY_W-1:0];
         delay_in = div_quo[DELAY_W-1:0];
      end
      if (cmd.store_pos_mod) begin
         pos_mod_in = div_rem[POS_W-1:0];
      end

      if (cmd.item_en) begin
         stepped_in = 1'b0;
         case (op)
            OP_TICK: begin
               elapsed_in = elapsed_inc;
               if (slot) begin
                  steps_in = steps_ff - 1'b1;
                  elapsed_in = '0;
                  stepped_in = 1'b1;
                  if (!blocked) begin
                     delay_in = half_ff ? (full_delay_ff >> 1) : full_delay_ff;
                     position_in = pos_next;
                     pos_mod_in = pos_next;
                     if (!half_ff) begin
                        if (en_used_ff) begin
                           enables_in = 2'd3;
                        end
                        if (four_wire_ff) begin
                           pins_in = full4_pat(pos_next[2:1]);
                        end else begin
                           pins_in = {pins_ff[3:2], full2_pat(pos_next[2:1])};
                        end
                     end else if (four_wire_ff) begin
                        pins_in = half4_pat(pos_next[2:0]);
                     end else begin
                        enables_in = half2_mask(pos_next[2:0]);
                        pins_in = (pins_ff & ~{2'b00, half2_mask(pos_next[2:0])})
                                  | {2'b00, half2_val(pos_next[2:0])};
                     end
                  end
               end
            end
            OP_MOVE: begin
               if (raw[15]) begin
                  steps_in = 16'd0 - raw;
                  forward_in = 1'b0;
               end else begin
                  steps_in = raw;
                  if (raw != '0) begin
                     forward_in = 1'b1;
                  end
               end
               half_in = half_mode;
            end
            OP_RELEASE: begin
               if (four_wire_ff) begin
                  pins_in = '0;
               end else if (en_used_ff) begin
                  enables_in = '0;
               end
            end
            default: begin
               stepped_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff <= SPR_RESET;
         rpm_ff <= RPM_RESET;
         four_wire_ff <= 1'b1;
         en_used_ff <= 1'b0;
         position_ff <= '0;
         pos_mod_ff <= '0;
         forward_ff <= 1'b0;
         steps_ff <= '0;
         elapsed_ff <= ELAPSED_MAX;
         delay_ff <= DELAY_RESET;
         full_delay_ff <= DELAY_RESET;
         half_ff <= 1'b0;
         pins_ff <= '0;
         enables_ff <= '0;
         stepped_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STEPS_PER_REV: spr_ff <= csr_data[SPR_W-1:0];
               CSR_SPEED_RPM:     rpm_ff <= csr_data[RPM_W-1:0];
               CSR_FOUR_WIRE:     four_wire_ff <= csr_data[0];
               CSR_COIL_EN_USED:  en_used_ff <= csr_data[0];
               default:           en_used_ff <= en_used_ff;
            endcase
         end
         position_ff <= position_in;
         pos_mod_ff <= pos_mod_in;
         forward_ff <= forward_in;
         steps_ff <= steps_in;
         elapsed_ff <= elapsed_in;
         delay_ff <= delay_in;
         full_delay_ff <= full_delay_in;
         half_ff <= half_in;
         pins_ff <= pins_in;
         enables_ff <= enables_in;
         stepped_ff <= stepped_in;
      end
      if (cmd.load_prod) begin
         prod_ff <= DIV_W'(rpm_eff) * DIV_W'(spr_eff);
      end
   end

   assign coil_pins = pins_ff;
   assign coil_enables = enables_ff;
   assign busy_res = steps_ff != '0;
   assign stepped = stepped_ff;
   assign position = position_ff;

endmodule

FILE: rtl/core/stepper_phase_sequencer.sv
// Top level of the stepper phase sequencer: controller, datapath and assertions.
//
//   Channel    Direction  Handshake            Carries
//   req_chan   in         valid/ready          op, move_steps, half_mode
//   rsp_chan   out        valid/ready          coil_pins, coil_enables, busy_res,
//                                              stepped, position
//   csr_*      in         csr_we, no wait      csr_index, csr_data
//
// Every accepted item produces exactly one result item in the following cycle.
// An item is taken in every cycle while the controller is idle and the result
// register is empty or being drained, so ticks can run at one per clock.
// A write to steps_per_rev or speed_rpm starts two passes of the shared
// bit-serial divider (step delay, then position reduction); req_chan.ready
// stays low from then until both passes and their control steps are done.
// Reset is synchronous; it loads the default configuration and a 5000 us delay
// directly, so no division runs after reset.
// A stalled result holds its payload because the state it shows only changes
// when the next item is accepted.
module stepper_phase_sequencer
   import sps_pkg::*;
#(
   parameter int ELAPSED_WIDTH = ELAPSED_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   sps_req_if.sink               req_chan,
   sps_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   sps_cmd_type    cmd;
   sps_status_type status;

   // The controller owns both handshakes and sequences the delay recomputation.
   sps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds configuration and motion state; its state registers
   // are shown directly as the result payload.
   sps_datapath #(.ELAPSED_WIDTH(ELAPSED_WIDTH)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .status       (status),
      .op           (req_chan.op),
      .move_steps   (req_chan.move_steps),
      .half_mode    (req_chan.half_mode),
      .coil_pins    (rsp_chan.coil_pins),
      .coil_enables (rsp_chan.coil_enables),
      .busy_res     (rsp_chan.busy_res),
      .stepped      (rsp_chan.stepped),
      .position     (rsp_chan.position)
   );

   // A new result only appears right after an accepted item.
   a_rsp_follows_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(req_chan.valid && req_chan.ready))
      else $error("result item appeared without an accepted item");

   // A delay-affecting register write blocks items while the divider runs.
   a_recalc_blocks: assert property (@(posedge clock) disable iff (reset)
      (csr_we && ((csr_index == CSR_STEPS_PER_REV) || (csr_index == CSR_SPEED_RPM)))
      |=> !req_chan.ready)
      else $error("item could be accepted during delay recomputation");

   // Only a tick can consume a step slot.
   a_step_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.op != OP_TICK))
      |=> !rsp_chan.stepped)
      else $error("step reported for an item that is not a tick");

   // A step slot is only consumed while a move was in progress.
   a_step_needs_move: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !rsp_chan.busy_res) |=> !rsp_chan.stepped)
      else $error("step taken with no steps remaining");

endmodule
